// File: sv/ajb_pkg.sv
// Shared types and constants for the audio jitter buffer.
// No dependencies; imported by every ajb_* module and the top level.
package ajb_pkg;

  localparam int unsigned DEPTH_DEFAULT       = 32768;
  localparam int unsigned MAX_PKT_DEFAULT     = 4096;
  localparam int unsigned HEADER_BYTES        = 8;
  localparam int unsigned PRELOAD_RESET       = 4096;
  localparam int unsigned QUEUE_DEPTH         = 2;   // power of two
  localparam int unsigned SAMPLE_W            = 16;
  localparam int unsigned LEVEL_W             = 16;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_PLAYED   = 3'd1,
    ST_SILENCE  = 3'd2,
    ST_COMMIT   = 3'd3,
    ST_REJECT   = 3'd4,
    ST_OVERRUN  = 3'd5
  } status_e;

  // Per-transaction control handed from the front to the back.
  typedef struct packed {
    logic                mem_wr;
    logic                mem_rd;
    status_e             status;
    logic                playing;
    logic [LEVEL_W-1:0]  fill_level;
  } meta_t;

endpackage

// File: sv/ajb_front.sv
// Front end: classifies transactions, tracks pointers, counts and play state.
// Emits one memory operation plus result fields per transaction. Uses ajb_pkg.
module ajb_front import ajb_pkg::*; #(
  parameter int unsigned DEPTH            = DEPTH_DEFAULT,
  parameter int unsigned MAX_PACKET_BYTES = MAX_PKT_DEFAULT,
  localparam int unsigned AW              = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [15:0]         preload_threshold_i,
  input  logic                accept_i,
  input  logic                command_i,
  input  logic [7:0]          packet_byte_i,
  input  logic                last_byte_i,
  output meta_t               meta_o,
  output logic [AW-1:0]       addr_o,
  output logic [SAMPLE_W-1:0] wdata_o
);

  localparam int unsigned FCW  = $clog2(DEPTH + 1);
  localparam int unsigned PCW  = $clog2(MAX_PACKET_BYTES / 2 + 1);
  localparam int unsigned BCW  = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned XW   = (FCW > LEVEL_W) ? FCW : LEVEL_W;
  localparam int unsigned TW   = ((FCW > PCW) ? FCW : PCW) + 1;

  logic [15:0]    thr_q;
  logic [AW-1:0]  commit_ptr_q, commit_ptr_d;
  logic [AW-1:0]  pend_ptr_q, pend_ptr_d;
  logic [AW-1:0]  read_ptr_q, read_ptr_d;
  logic [FCW-1:0] fill_q, fill_d;
  logic [PCW-1:0] pend_cnt_q, pend_cnt_d;
  logic [BCW-1:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]     low_q, low_d;
  logic           play_q, play_d;

  logic           play_start;
  logic [TW-1:0]  total;
  logic           len_ok;
  logic [XW-1:0]  fill_x;
  status_e        status;
  logic           mem_wr, mem_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'(PRELOAD_RESET);
    end else if (cfg_valid_i) begin
      thr_q <= preload_threshold_i;
    end
  end

  function automatic logic [AW-1:0] ptr_next(logic [AW-1:0] p);
    ptr_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    commit_ptr_d = commit_ptr_q;
    pend_ptr_d   = pend_ptr_q;
    read_ptr_d   = read_ptr_q;
    fill_d       = fill_q;
    pend_cnt_d   = pend_cnt_q;
    byte_cnt_d   = byte_cnt_q;
    low_d        = low_q;
    play_d       = play_q;
    status       = ST_BYTE;
    mem_wr       = 1'b0;
    mem_rd       = 1'b0;
    addr_o       = read_ptr_q;
    wdata_o      = {packet_byte_i, low_q};
    total        = '0;
    len_ok       = 1'b0;
    play_start   = (XW'(fill_q) >= XW'(thr_q));

    if (command_i) begin
      play_d = play_q | play_start;
      if (play_d && fill_q != '0) begin
        mem_rd     = 1'b1;
        read_ptr_d = ptr_next(read_ptr_q);
        fill_d     = fill_q - 1'b1;
        status     = ST_PLAYED;
      end else begin
        status     = ST_SILENCE;
      end
      if (play_d && fill_d == '0) begin
        play_d = 1'b0;
      end
    end else begin
      // header offset is even, so payload byte parity is the counter's LSB
      if (byte_cnt_q >= BCW'(HEADER_BYTES) && byte_cnt_q < BCW'(MAX_PACKET_BYTES)) begin
        if (!byte_cnt_q[0]) begin
          low_d = packet_byte_i;
        end else begin
          mem_wr     = 1'b1;
          addr_o     = pend_ptr_q;
          pend_ptr_d = ptr_next(pend_ptr_q);
          pend_cnt_d = pend_cnt_q + 1'b1;
        end
      end
      if (byte_cnt_q < BCW'(MAX_PACKET_BYTES + 1)) begin
        byte_cnt_d = byte_cnt_q + 1'b1;
      end

      if (last_byte_i) begin
        len_ok = (byte_cnt_d > BCW'(HEADER_BYTES)) &&
                 (byte_cnt_d <= BCW'(MAX_PACKET_BYTES)) && !byte_cnt_d[0];
        total  = TW'(fill_q) + TW'(pend_cnt_d);
        if (len_ok) begin
          commit_ptr_d = pend_ptr_d;
          if (total > TW'(DEPTH)) begin
            read_ptr_d = pend_ptr_d;
            fill_d     = FCW'(DEPTH);
            status     = ST_OVERRUN;
          end else begin
            fill_d     = FCW'(total);
            status     = ST_COMMIT;
          end
        end else begin
          status = ST_REJECT;
        end
        byte_cnt_d = '0;
        pend_cnt_d = '0;
        low_d      = '0;
        pend_ptr_d = commit_ptr_d;
      end
    end
  end

  assign fill_x            = XW'(fill_d);
  assign meta_o.mem_wr     = mem_wr;
  assign meta_o.mem_rd     = mem_rd;
  assign meta_o.status     = status;
  assign meta_o.playing    = play_d;
  assign meta_o.fill_level = fill_x[LEVEL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_ptr_q <= '0;
      pend_ptr_q   <= '0;
      read_ptr_q   <= '0;
      fill_q       <= '0;
      pend_cnt_q   <= '0;
      byte_cnt_q   <= '0;
      low_q        <= '0;
      play_q       <= 1'b0;
    end else if (accept_i) begin
      commit_ptr_q <= commit_ptr_d;
      pend_ptr_q   <= pend_ptr_d;
      read_ptr_q   <= read_ptr_d;
      fill_q       <= fill_d;
      pend_cnt_q   <= pend_cnt_d;
      byte_cnt_q   <= byte_cnt_d;
      low_q        <= low_d;
      play_q       <= play_d;
    end
  end

endmodule

// File: sv/ajb_queue.sv
// Small register FIFO between front and back end.
// Uses ajb_pkg for its depth.
module ajb_queue import ajb_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         ready_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]   slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q;

  assign ready_o    = (count_q != QCW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/ajb_back.sv
// Back end: sample memory and output register.
// Executes queued writes and reads in order. Uses ajb_pkg.
module ajb_back import ajb_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  output logic                       op_pop_o,
  input  meta_t                      meta_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [SAMPLE_W-1:0]        wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [2:0]                 status_o,
  output logic                       playing_o,
  output logic [LEVEL_W-1:0]         fill_level_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  meta_t               meta_q;
  logic                out_valid_q;

  assign op_pop_o = op_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (op_pop_o && meta_i.mem_wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (op_pop_o && meta_i.mem_rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = meta_q.mem_rd ? rdata_q : '0;
  assign status_o     = meta_q.status;
  assign playing_o    = meta_q.playing;
  assign fill_level_o = meta_q.fill_level;

endmodule

// File: sv/audio_jitter_buffer_unit.sv
// Top level of the audio playout jitter buffer: front, queue, back.
// Depends on ajb_pkg, ajb_front, ajb_queue, ajb_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | preload_threshold_i
//   in      | in        | in_valid_i/in_ready_o   | command_i, packet_byte_i, last_byte_i
//   out     | out       | out_valid_o/out_ready_i | sample_out_o, status_o, playing_o,
//           |           |                         | fill_level_o
//
// One transaction per cycle sustained while out_ready_i stays high. The front
// updates its pointers in the accept cycle, the back does the memory access
// when it pops the queue entry and registers the result. Reset clears all
// pointers, counts and play state; the sample memory is not cleared. A stalled
// output fills the two-entry queue, after which in_ready_o drops. cfg is always ready.
module audio_jitter_buffer_unit import ajb_pkg::*; #(
  parameter int unsigned DEPTH            = DEPTH_DEFAULT,
  parameter int unsigned MAX_PACKET_BYTES = MAX_PKT_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [15:0]                preload_threshold_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [7:0]                 packet_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic [2:0]                 status_o,
  output logic                       playing_o,
  output logic [LEVEL_W-1:0]         fill_level_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned MW = $bits(meta_t);
  localparam int unsigned QW = MW + AW + SAMPLE_W;

  logic                accept;
  meta_t               f_meta, b_meta;
  logic [AW-1:0]       f_addr, b_addr;
  logic [SAMPLE_W-1:0] f_wdata, b_wdata;
  logic [QW-1:0]       q_out;
  logic                q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  ajb_front #(
    .DEPTH            (DEPTH),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .preload_threshold_i (preload_threshold_i),
    .accept_i            (accept),
    .command_i           (command_i),
    .packet_byte_i       (packet_byte_i),
    .last_byte_i         (last_byte_i),
    .meta_o              (f_meta),
    .addr_o              (f_addr),
    .wdata_o             (f_wdata)
  );

  ajb_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i ({f_meta, f_addr, f_wdata}),
    .ready_o     (in_ready_o),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  assign b_meta  = meta_t'(q_out[QW-1 -: MW]);
  assign b_addr  = q_out[SAMPLE_W +: AW];
  assign b_wdata = q_out[SAMPLE_W-1:0];

  ajb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_pop_o     (q_pop),
    .meta_i       (b_meta),
    .addr_i       (b_addr),
    .wdata_i      (b_wdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .status_o     (status_o),
    .playing_o    (playing_o),
    .fill_level_o (fill_level_o)
  );

endmodule
